// File: hdl/fra_pkg.sv
// ----------------------------------------------------------------------------
// fra_pkg
// Shared types and codes for the FIFO-reuse handle allocator.
// ----------------------------------------------------------------------------
package fra_pkg;

  localparam int HandleW = 8;

  typedef logic [HandleW-1:0] handle_t;
  typedef logic [1:0]         req_code_t;

  // Request codes. The fourth code is unused and is answered as an invalid free.
  localparam req_code_t REQ_ALLOC = 2'd0;
  localparam req_code_t REQ_TRY   = 2'd1;
  localparam req_code_t REQ_FREE  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NONE      = 2'd1,
    ST_INVALID   = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  // Free-queue control from the allocator core.
  typedef struct packed {
    logic    push;
    logic    pop;
    handle_t push_data;
  } q_ctrl_t;

  // Free-queue status back to the allocator core.
  typedef struct packed {
    logic    empty;
    logic    full;
    handle_t head_data;
  } q_stat_t;

  // Active bitmap control.
  typedef struct packed {
    logic    set_en;
    handle_t set_idx;
    logic    clr_en;
    handle_t clr_idx;
    handle_t rd_idx;
  } act_ctrl_t;

endpackage

// File: hdl/fra_if.sv
// ----------------------------------------------------------------------------
// fra_req_if / fra_rsp_if
// Valid/ready channels for allocator requests and their results.
// ----------------------------------------------------------------------------
interface fra_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  fra_pkg::handle_t  handle_in;

  modport source (output valid, output req_type, output handle_in, input ready);
  modport sink   (input valid, input req_type, input handle_in, output ready);
endinterface

interface fra_rsp_if;
  logic              valid;
  logic              ready;
  fra_pkg::handle_t  handle_out;
  logic [1:0]        status;

  modport source (output valid, output handle_out, output status, input ready);
  modport sink   (input valid, input handle_out, input status, output ready);
endinterface

// File: hdl/fifo_reuse_handle_allocator_unit.sv
// ----------------------------------------------------------------------------
// fifo_reuse_handle_allocator_unit
// Handle allocator that reuses freed handles oldest first.
// ----------------------------------------------------------------------------
// The unit accepts one request per cycle while its output is not stalled, and
// returns each result through two registers: the request is captured in an
// input register, executed against the free queue and the active bitmap, and
// the result is held in an output register. The oldest freed handle is always
// waiting in the free queue's registered read port, so a pop can use it in
// the same cycle. The active bitmap is flops cleared by reset, so the unit is
// ready right after reset. Only handles below 256 can be freed, so the free
// queue and bitmap hold min(POOL_SIZE, 256) entries; fresh grants at or above
// 256 are never marked active, so they can never be returned.
// ----------------------------------------------------------------------------
module fifo_reuse_handle_allocator_unit #(
  parameter int POOL_SIZE = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  fra_req_if.sink          in_if,
  fra_rsp_if.source        out_if
);
  import fra_pkg::*;

  localparam int ActN = (POOL_SIZE < 256) ? POOL_SIZE : 256;
  localparam int NFW  = $clog2(POOL_SIZE + 1);

  // Input register.
  logic       in_valid_r;
  req_code_t  req_r;
  handle_t    hin_r;

  // Result register.
  logic       out_valid_r, out_valid_nxt;
  handle_t    out_handle_r;
  status_t    out_status_r;

  logic [NFW-1:0] nf_r, nf_nxt;

  q_ctrl_t   q_ctrl;
  q_stat_t   q_stat;
  act_ctrl_t a_ctrl;
  logic      act_bit;

  logic      exec_fire;
  logic      hin_in_pool;
  logic      exhausted;
  logic      fresh_trackable;
  handle_t   res_handle;
  status_t   res_status;

  assign exec_fire    = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !in_valid_r || exec_fire;

  assign hin_in_pool     = (32'(hin_r) < POOL_SIZE);
  assign exhausted       = (nf_r == NFW'(POOL_SIZE));
  assign fresh_trackable = (nf_r < NFW'(ActN));

  always_comb begin
    q_ctrl         = '0;
    a_ctrl         = '0;
    a_ctrl.rd_idx  = hin_r;
    q_ctrl.push_data = hin_r;
    a_ctrl.clr_idx = hin_r;
    nf_nxt         = nf_r;
    res_handle     = '0;
    res_status     = ST_OK;
    case (req_r)
      REQ_ALLOC, REQ_TRY: begin
        if (!q_stat.empty) begin
          res_handle     = q_stat.head_data;
          q_ctrl.pop     = exec_fire;
          a_ctrl.set_en  = exec_fire;
          a_ctrl.set_idx = q_stat.head_data;
        end else if (req_r == REQ_TRY) begin
          res_status = ST_NONE;
        end else if (exhausted) begin
          res_status = ST_EXHAUSTED;
        end else begin
          res_handle     = 8'(nf_r);
          a_ctrl.set_en  = exec_fire && fresh_trackable;
          a_ctrl.set_idx = 8'(nf_r);
          if (exec_fire) begin
            nf_nxt = nf_r + NFW'(1);
          end
        end
      end
      REQ_FREE: begin
        if (hin_in_pool && act_bit && !q_stat.full) begin
          q_ctrl.push   = exec_fire;
          a_ctrl.clr_en = exec_fire;
        end else begin
          res_status = ST_INVALID;
        end
      end
      default: begin
        res_status = ST_INVALID;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      nf_r        <= '0;
    end else begin
      if (in_if.ready) begin
        in_valid_r <= in_if.valid;
      end
      out_valid_r <= out_valid_nxt;
      nf_r        <= nf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      req_r <= in_if.req_type;
      hin_r <= in_if.handle_in;
    end
    if (exec_fire) begin
      out_handle_r <= res_handle;
      out_status_r <= res_status;
    end
  end

  fra_free_queue #(
    .Depth (ActN)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (q_ctrl),
    .stat  (q_stat)
  );

  fra_active_map #(
    .Entries (ActN)
  ) u_active (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (a_ctrl),
    .rd_bit (act_bit)
  );

  assign out_if.valid      = out_valid_r;
  assign out_if.handle_out = out_handle_r;
  assign out_if.status     = out_status_r;

  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nf_r <= NFW'(POOL_SIZE))
    else $error("fresh handle counter beyond pool");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> out_handle_r == '0)
    else $error("failed request carries a nonzero handle");

  a_one_queue_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_ctrl.push && q_ctrl.pop) && !(a_ctrl.set_en && a_ctrl.clr_en))
    else $error("request drove both a grant and a free");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |=> out_valid_r)
    else $error("executed request produced no result");

endmodule

// File: hdl/fra_free_queue.sv
// ----------------------------------------------------------------------------
// fra_free_queue
// FIFO of freed handles in a single-port-write, registered-read memory.
// The head entry is prefetched so that a pop can use it in the same cycle.
// ----------------------------------------------------------------------------
module fra_free_queue #(
  parameter int Depth = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  fra_pkg::q_ctrl_t ctrl,
  output fra_pkg::q_stat_t stat
);
  import fra_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  handle_t       mem [Depth];
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  handle_t       rd_data_r;

  function automatic logic [AW-1:0] step_ptr(input logic [AW-1:0] p);
    step_ptr = (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  always_comb begin
    head_nxt  = ctrl.pop  ? step_ptr(head_r) : head_r;
    tail_nxt  = ctrl.push ? step_ptr(tail_r) : tail_r;
    count_nxt = count_r;
    if (ctrl.push && !ctrl.pop) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.pop && !ctrl.push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Write port, plus a read of the next head with forwarding when the same
  // entry is written in this cycle.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[tail_r] <= ctrl.push_data;
    end
    if (ctrl.push && (tail_r == head_nxt)) begin
      rd_data_r <= ctrl.push_data;
    end else begin
      rd_data_r <= mem[head_nxt];
    end
  end

  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == CW'(Depth));
  assign stat.head_data = rd_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(Depth))
    else $error("free queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop |-> count_r != '0)
    else $error("pop from empty free queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0 && count_r != CW'(Depth)) |-> head_r != tail_r)
    else $error("free queue pointers disagree with count");

endmodule

// File: hdl/fra_active_map.sv
// ----------------------------------------------------------------------------
// fra_active_map
// One flop per freeable handle, set on grant and cleared on free.
// ----------------------------------------------------------------------------
module fra_active_map #(
  parameter int Entries = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fra_pkg::act_ctrl_t ctrl,
  output logic               rd_bit
);
  import fra_pkg::*;

  localparam int AW = (Entries > 1) ? $clog2(Entries) : 1;

  logic [Entries-1:0] bits_r, bits_nxt;

  always_comb begin
    bits_nxt = bits_r;
    if (ctrl.set_en) begin
      bits_nxt[ctrl.set_idx[AW-1:0]] = 1'b1;
    end
    if (ctrl.clr_en) begin
      bits_nxt[ctrl.clr_idx[AW-1:0]] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
    end else begin
      bits_r <= bits_nxt;
    end
  end

  assign rd_bit = bits_r[ctrl.rd_idx[AW-1:0]];

endmodule
